>>> hdl/rlzd_pkg.sv
`timescale 1ns / 1ps
package rlzd_pkg;
	localparam int unsigned HIST_DEPTH = 131072;
	localparam int unsigned HIST_AW = 17;
	localparam int unsigned BEAT_BYTES = 32;
	localparam int unsigned CNT_W = 6;

	localparam logic [2:0] ST_PENDING = 3'd0;
	localparam logic [2:0] ST_OK = 3'd1;
	localparam logic [2:0] ST_TRUNC = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd4;
	localparam logic [2:0] ST_AFTER_STOP = 3'd5;
	localparam logic [2:0] ST_SHORT = 3'd6;

	localparam logic CFG_STOP_THRESHOLD = 1'b0;
	localparam logic CFG_OUTPUT_SIZE = 1'b1;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [63:0]      word3;
		logic [63:0]      word2;
		logic [63:0]      word1;
		logic [63:0]      word0;
		logic [CNT_W-1:0] byte_count;
		logic             run_end;
		logic             stream_done;
		logic [2:0]       status;
	} out_item_t;

	typedef struct packed {
		logic        index;
		logic [31:0] data;
	} cfg_item_t;

	function automatic logic [2:0] opcode_size(input logic [7:0] b0);
		if (b0 <= 8'h7F) return 3'd2;
		if (b0 <= 8'hBF) return 3'd3;
		if (b0 <= 8'hDF) return 3'd4;
		return 3'd1;
	endfunction
endpackage

>>> hdl/rlzd_if.sv
`timescale 1ns / 1ps
interface rlzd_in_if;
	import rlzd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rlzd_out_if;
	import rlzd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rlzd_cfg_if;
	import rlzd_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/rlzd_ram.sv
`timescale 1ns / 1ps
module rlzd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/refpack_lz_decompressor.sv
`timescale 1ns / 1ps
// RefPack stream decompressor: one compressed byte per input request, results as beats of up to
// 32 bytes. A literal or opcode byte goes through accept, parse and beat handoff. A match of
// length L copies L bytes more, each read from the 128 KiB history RAM (one read port,
// registered read) and written back on the next cycle, so a copy at offset 1 sees the byte just
// written. Each full beat is handed off before the match goes on. Input is not ready while a
// byte is being worked or a beat waits for its output register.
module refpack_lz_decompressor (
	input logic       clk,
	input logic       arst_n,
	rlzd_cfg_if.sink  cfg,
	rlzd_in_if.sink   in_ch,
	rlzd_out_if.source out_ch
);
	import rlzd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PARSE = 5'b00010,
		S_COPY  = 5'b00100,
		S_FLUSH = 5'b01000,
		S_SEND  = 5'b10000
	} state_t;

	state_t state_q;
	logic [7:0]  thr_q;
	logic [31:0] osize_q;
	logic [31:0] written_q;
	logic [1:0]  phase_q;
	logic [15:0] opb_q;
	logic [7:0]  lits_q;
	logic [10:0] mlen_q;
	logic [17:0] moff_q;
	logic        stop_q;
	logic [2:0]  err_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  beat_q [BEAT_BYTES];
	logic [CNT_W-1:0] fill_q;
	logic [10:0] clen_q;
	logic        rd_pend_q;
	logic        final_q;
	out_item_t   out_q;
	logic        ovalid_q;

	logic        we;
	logic [7:0]  wdata;
	logic [HIST_AW-1:0] raddr;
	logic [7:0]  rdata;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = out_q;

	rlzd_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
		.clk(clk), .we(we), .waddr(written_q[HIST_AW-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// parse decode of current byte
	logic [7:0]  b0, b1, b2, thr_eff, smask;
	logic [2:0]  need;
	logic [31:0] room;
	logic [7:0]  lit_d;
	logic [10:0] len_d;
	logic [17:0] off_d;
	always_comb begin
		b0 = opb_q[7:0];
		b1 = opb_q[15:8];
		b2 = lits_q;
		thr_eff = (thr_q == 8'd0) ? 8'hFB : thr_q;
		if (thr_eff >= 8'hFF) smask = 8'h1F;
		else if (thr_eff >= 8'hFE) smask = 8'h00;
		else if (thr_eff >= 8'hFD) smask = 8'h01;
		else if (thr_eff >= 8'hFB) smask = 8'h03;
		else if (thr_eff >= 8'hF7) smask = 8'h07;
		else smask = 8'h0F;
		need = opcode_size(b0);
		room = osize_q - written_q;
		lit_d = {6'd0, b0[1:0]};
		len_d = 11'd0;
		off_d = 18'd0;
		unique case (need)
			3'd2: begin
				len_d = {8'd0, b0[4:2]} + 11'd3;
				off_d = {8'd0, b0[6:5], byte_q} + 18'd1;
			end
			3'd3: begin
				len_d = {5'd0, b0[5:0]} + 11'd4;
				lit_d = {6'd0, b1[7:6]};
				off_d = {4'd0, b1[5:0], byte_q} + 18'd1;
			end
			default: begin
				len_d = {1'b0, b0[3:2], 8'd0} + 11'd5 + {3'd0, byte_q};
				off_d = {1'b0, b0[4], b1, b2} + 18'd1;
			end
		endcase
	end

	// literals pending flag (lits_q doubles as third opcode byte during parse)
	logic lits_q_live;
	assign lits_q_live = (phase_q == 2'd0) && (lits_q != 8'd0);

	logic [2:0] final_st;
	always_comb begin
		if (err_q != ST_PENDING) final_st = err_q;
		else if (phase_q != 2'd0 || lits_q_live) final_st = ST_TRUNC;
		else if (!stop_q || written_q != osize_q) final_st = ST_SHORT;
		else final_st = ST_OK;
	end

	// shared beat buffer write
	logic        put;
	logic [7:0]  put_byte;
	assign we = put;
	assign wdata = put_byte;
	assign raddr = written_q[HIST_AW-1:0] - moff_q[HIST_AW-1:0];

	logic [255:0] beat_flat;
	always_comb begin
		for (int i = 0; i < BEAT_BYTES; i++) beat_flat[i*8 +: 8] = beat_q[i];
	end

	always_comb begin
		put = 1'b0;
		put_byte = rdata;
		if (state_q == S_PARSE && err_q == ST_PENDING && !(stop_q && phase_q == 2'd0
				&& lits_q == 8'd0) && lits_q_live) begin
			put = 1'b1;
			put_byte = byte_q;
		end else if (state_q == S_COPY && rd_pend_q && fill_q != CNT_W'(BEAT_BYTES)) begin
			put = 1'b1;
		end
	end

	// a match starts copying: check overflow then offset
	task automatic start_match(input logic [10:0] len, input logic [17:0] off,
			input logic [31:0] wr, output logic go, output logic [2:0] e);
		go = 1'b0;
		e = ST_PENDING;
		if ({21'd0, len} > osize_q - wr) e = ST_OVERFLOW;
		else if ({14'd0, off} > wr || off == 18'd0) e = ST_BAD_OFFSET;
		else go = 1'b1;
	endtask

	function automatic logic [63:0] mask64(input logic [CNT_W-1:0] n, input int w);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (CNT_W'(w * 8 + i) < n) m[i*8 +: 8] = 8'hFF;
		return m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= 8'hFB;
			osize_q <= '0;
			written_q <= '0;
			phase_q <= '0;
			opb_q <= '0;
			lits_q <= '0;
			mlen_q <= '0;
			moff_q <= '0;
			stop_q <= 1'b0;
			err_q <= ST_PENDING;
			fill_q <= '0;
			clen_q <= '0;
			rd_pend_q <= 1'b0;
			final_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin : seq
			logic go;
			logic [2:0] e;
			state_t pnext;
			if (cfg.valid) begin
				if (cfg.data.index == CFG_STOP_THRESHOLD) thr_q <= cfg.data.data[7:0];
				else osize_q <= cfg.data.data;
			end
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			if (put) begin
				beat_q[fill_q[4:0]] <= put_byte;
				fill_q <= fill_q + CNT_W'(1);
				written_q <= written_q + 32'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						byte_q <= in_ch.data.byte_in;
						last_q <= in_ch.data.last;
						fill_q <= '0;
						state_q <= S_PARSE;
					end
				end
				S_PARSE: begin
					pnext = S_FLUSH;
					if (err_q != ST_PENDING) begin
					end else if (stop_q && phase_q == 2'd0 && lits_q == 8'd0) begin
						err_q <= ST_AFTER_STOP;
					end else if (lits_q_live) begin
						lits_q <= lits_q - 8'd1;
						if (lits_q == 8'd1 && mlen_q != 11'd0) begin
							mlen_q <= '0;
							start_match(mlen_q, moff_q, written_q + 32'd1, go, e);
							err_q <= e;
							if (go) begin
								clen_q <= mlen_q;
								rd_pend_q <= 1'b0;
								pnext = S_COPY;
							end
						end
					end else if (phase_q == 2'd0) begin
						if (opcode_size(byte_q) > 3'd1) begin
							opb_q <= {8'd0, byte_q};
							phase_q <= 2'd1;
						end else if (byte_q <= thr_eff) begin
							if ({25'd0, byte_q[4:0], 2'b00} + 32'd4 > room)
								err_q <= ST_OVERFLOW;
							else lits_q <= {1'b0, byte_q[4:0], 2'b00} + 8'd4;
						end else begin
							stop_q <= 1'b1;
							if ({24'd0, byte_q & smask} > room) err_q <= ST_OVERFLOW;
							else lits_q <= byte_q & smask;
						end
					end else if ({1'b0, phase_q} + 3'd1 < need) begin
						if (phase_q == 2'd1) opb_q[15:8] <= byte_q;
						else lits_q <= byte_q;
						phase_q <= phase_q + 2'd1;
					end else begin
						phase_q <= '0;
						opb_q <= '0;
						if ({24'd0, lit_d} > room) begin
							err_q <= ST_OVERFLOW;
							lits_q <= '0;
						end else begin
							lits_q <= lit_d;
							moff_q <= off_d;
							if (lit_d == 8'd0) begin
								mlen_q <= '0;
								start_match(len_d, off_d, written_q, go, e);
								err_q <= e;
								if (go) begin
									clen_q <= len_d;
									rd_pend_q <= 1'b0;
									pnext = S_COPY;
								end
							end else mlen_q <= len_d;
						end
					end
					state_q <= pnext;
				end
				S_COPY: begin
					// read issued on entry cycle, data lands next cycle
					if (fill_q == CNT_W'(BEAT_BYTES) && clen_q != 11'd0) begin
						if (!ovalid_q) begin
							out_q <= '{word0: beat_flat[63:0], word1: beat_flat[127:64],
								word2: beat_flat[191:128], word3: beat_flat[255:192],
								byte_count: fill_q, run_end: 1'b0, stream_done: 1'b0,
								status: ST_PENDING};
							ovalid_q <= 1'b1;
							fill_q <= '0;
						end
					end else if (!rd_pend_q) begin
						if (clen_q == 11'd0) state_q <= S_FLUSH;
						else begin
							rd_pend_q <= 1'b1;
							clen_q <= clen_q - 11'd1;
						end
					end else rd_pend_q <= 1'b0;
				end
				S_FLUSH: begin
					if (fill_q == CNT_W'(BEAT_BYTES) || (fill_q != '0 && !last_q)
							|| last_q) begin
						if (!ovalid_q) begin
							if (fill_q == '0 && !last_q) state_q <= S_IDLE;
							else begin
								out_q <= '{word0: beat_flat[63:0] & mask64(fill_q, 0),
									word1: beat_flat[127:64] & mask64(fill_q, 1),
									word2: beat_flat[191:128] & mask64(fill_q, 2),
									word3: beat_flat[255:192] & mask64(fill_q, 3),
									byte_count: fill_q, run_end: 1'b1,
									stream_done: last_q,
									status: last_q ? final_st : ST_PENDING};
								ovalid_q <= 1'b1;
								state_q <= S_IDLE;
								if (last_q) begin
									written_q <= '0;
									phase_q <= '0;
									opb_q <= '0;
									lits_q <= '0;
									mlen_q <= '0;
									moff_q <= '0;
									stop_q <= 1'b0;
									err_q <= ST_PENDING;
								end
							end
						end
					end else state_q <= S_IDLE;
				end
				S_SEND: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(BEAT_BYTES)) else $error("beat overfilled");
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.stream_done |-> out_ch.data.status != ST_PENDING)
		else $error("final beat without status");
`endif
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rlzd_pkg::*;

	class refpack_expander;
		bit [7:0]    thr_reg;
		bit [31:0]   size_reg;
		bit [7:0]    hist [HIST_DEPTH];
		bit [31:0]   nwr;
		int unsigned phase;
		bit [23:0]   opb;
		int unsigned lits_left;
		bit [31:0]   mlen;
		bit [31:0]   mdist;
		bit          stopped;
		bit [2:0]    err;
		bit [7:0]    fresh[$];
		out_item_t   beats_due[$];
		int unsigned fails;

		function new();
			thr_reg = 8'hFB;
			size_reg = 0;
			fails = 0;
			clear();
		endfunction

		function void clear();
			nwr = 0;
			phase = 0;
			opb = 0;
			lits_left = 0;
			mlen = 0;
			mdist = 0;
			stopped = 0;
			err = ST_PENDING;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == CFG_STOP_THRESHOLD)
				thr_reg = val[7:0];
			else
				size_reg = val;
		endfunction

		function void put(bit [7:0] b);
			hist[nwr % HIST_DEPTH] = b;
			nwr++;
			fresh.push_back(b);
		endfunction

		function void expand();
			bit [31:0] len;
			len = mlen;
			mlen = 0;
			if (len > size_reg - nwr) begin
				err = ST_OVERFLOW;
				return;
			end
			if (mdist > nwr || mdist == 0) begin
				err = ST_BAD_OFFSET;
				return;
			end
			for (int unsigned i = 0; i < len; i++)
				put(hist[(nwr - mdist) % HIST_DEPTH]);
		endfunction

		function void op_done(bit [31:0] lit, bit [31:0] len, bit [31:0] moff);
			if (lit > size_reg - nwr) begin
				err = ST_OVERFLOW;
				return;
			end
			lits_left = lit;
			mlen = len;
			mdist = moff;
			if (lit == 0 && len != 0)
				expand();
		endfunction

		function int unsigned op_bytes(bit [7:0] b0);
			if (b0 < 8'h80) return 2;
			if (b0 < 8'hC0) return 3;
			if (b0 < 8'hE0) return 4;
			return 1;
		endfunction

		function void parse(bit [7:0] b);
			bit [7:0]    b0, b1, b2, thr, mask;
			int unsigned need;
			bit [31:0]   lit, len, off;
			if (phase == 0) begin
				if (op_bytes(b) > 1) begin
					opb = {16'h0, b};
					phase = 1;
					return;
				end
				thr = thr_reg ? thr_reg : 8'hFB;
				if (thr == 8'hFF) mask = 8'h1F;
				else if (thr == 8'hFE) mask = 8'h00;
				else if (thr == 8'hFD) mask = 8'h01;
				else if (thr >= 8'hFB) mask = 8'h03;
				else if (thr >= 8'hF7) mask = 8'h07;
				else mask = 8'h0F;
				if (b <= thr)
					op_done((b[4:0] + 32'd1) << 2, 0, 0);
				else begin
					stopped = 1;
					op_done(b & mask, 0, 0);
				end
				return;
			end
			b0 = opb[7:0];
			need = op_bytes(b0);
			if (phase + 1 < need) begin
				opb[8*phase +: 8] = b;
				phase++;
				return;
			end
			b1 = opb[15:8];
			b2 = opb[23:16];
			phase = 0;
			opb = 0;
			if (need == 2) begin
				lit = b0[1:0];
				len = b0[4:2] + 32'd3;
				off = {b0[6:5], b};
			end else if (need == 3) begin
				len = b0[5:0] + 32'd4;
				lit = b1[7:6];
				off = {b1[5:0], b};
			end else begin
				lit = b0[1:0];
				len = {b0[3:2], 8'h0} + 32'd5 + b;
				off = {b0[4], b1, b2};
			end
			op_done(lit, len, off + 32'd1);
		endfunction

		function void accept_byte(bit [7:0] b, bit last);
			int unsigned nb, start, n;
			bit [255:0]  pack;
			bit [2:0]    st;
			out_item_t   item;
			fresh.delete();
			if (err == ST_PENDING) begin
				if (stopped && phase == 0 && lits_left == 0)
					err = ST_AFTER_STOP;
				else if (lits_left > 0) begin
					put(b);
					lits_left--;
					if (lits_left == 0 && mlen != 0)
						expand();
				end else
					parse(b);
			end
			if (err != ST_PENDING) st = err;
			else if (phase != 0 || lits_left != 0) st = ST_TRUNC;
			else if (!stopped || nwr != size_reg) st = ST_SHORT;
			else st = ST_OK;
			nb = (fresh.size() + BEAT_BYTES - 1) / BEAT_BYTES;
			if (nb == 0 && last) nb = 1;
			for (int unsigned k = 0; k < nb; k++) begin
				start = k * BEAT_BYTES;
				n = fresh.size() > start ? fresh.size() - start : 0;
				if (n > BEAT_BYTES) n = BEAT_BYTES;
				pack = '0;
				for (int unsigned i = 0; i < n; i++)
					pack[8*i +: 8] = fresh[start + i];
				item = '0;
				item.word0 = pack[63:0];
				item.word1 = pack[127:64];
				item.word2 = pack[191:128];
				item.word3 = pack[255:192];
				item.byte_count = CNT_W'(n);
				item.run_end = (k + 1 == nb);
				if (last && k + 1 == nb) begin
					item.stream_done = 1;
					item.status = st;
				end else
					item.status = ST_PENDING;
				beats_due.push_back(item);
			end
			if (last)
				clear();
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				fails++;
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
			end
		endfunction

		function void check_beat(out_item_t got);
			out_item_t e;
			if (beats_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected beat: expected none, got %h", $time, got);
				return;
			end
			e = beats_due.pop_front();
			cmp("word0", e.word0, got.word0);
			cmp("word1", e.word1, got.word1);
			cmp("word2", e.word2, got.word2);
			cmp("word3", e.word3, got.word3);
			cmp("byte_count", e.byte_count, got.byte_count);
			cmp("run_end", e.run_end, got.run_end);
			cmp("stream_done", e.stream_done, got.stream_done);
			cmp("status", e.status, got.status);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	rlzd_cfg_if cfg();
	rlzd_in_if  in_ch();
	rlzd_out_if out_ch();

	refpack_lz_decompressor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	refpack_expander model = new();
	bit          calm;
	int unsigned quiet;
	int unsigned sent;
	bit [7:0]    thr_now;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		cfg.valid = 0;
		cfg.data = '0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if ((cfg.valid && cfg.ready) || (in_ch.valid && in_ch.ready) ||
				(out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 6000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned stall;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall) begin
				out_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			model.check_beat(out_ch.data);
		end
	end

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg.valid <= 1;
		cfg.data <= '{index: idx, data: val};
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		model.set_reg(idx, val);
		if (idx == CFG_STOP_THRESHOLD) thr_now = val[7:0];
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_byte(bit [7:0] b, bit last);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= '{byte_in: b, last: last};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		model.accept_byte(b, last);
		sent++;
	endtask

	task automatic send_stream(bit [7:0] s[$]);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (model.beats_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic void push_lits(ref bit [7:0] s[$], input int unsigned n);
		repeat (n) s.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void gen_stream(ref bit [7:0] s[$], ref int unsigned prod);
		int unsigned eff, nops, kind, lit, len, off, lim, hi, lo, b, mask, x;
		eff = thr_now ? thr_now : 8'hFB;
		nops = $urandom_range(1, 6);
		s.delete();
		prod = 0;
		for (int k = 0; k < nops; k++) begin
			kind = $urandom_range(0, 3);
			if (kind == 0 && eff >= 8'hE0) begin
				hi = eff - 8'hE0;
				if (hi > 31) hi = 31;
				if (hi > 3 && $urandom_range(0, 7) != 0) hi = 3;
				b = $urandom_range(0, hi);
				s.push_back(8'(8'hE0 + b));
				push_lits(s, (b + 1) * 4);
				prod += (b + 1) * 4;
			end else begin
				lit = $urandom_range(0, 3);
				if (prod + lit == 0) lit = $urandom_range(1, 3);
				lim = prod + lit - 1;
				if ($urandom_range(0, 19) == 0) lim = prod + lit + 4;
				if (kind <= 1) begin
					len = $urandom_range(3, 10);
					off = $urandom_range(0, lim > 1023 ? 1023 : lim);
					s.push_back(8'(lit | ((len - 3) << 2) | ((off >> 8) << 5)));
					s.push_back(8'(off & 8'hFF));
				end else if (kind == 2) begin
					len = $urandom_range(4, 67);
					off = $urandom_range(0, lim > 16383 ? 16383 : lim);
					s.push_back(8'(8'h80 | (len - 4)));
					s.push_back(8'((lit << 6) | (off >> 8)));
					s.push_back(8'(off & 8'hFF));
				end else begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 1028)
						: $urandom_range(5, 60);
					off = $urandom_range(0, lim > 131071 ? 131071 : lim);
					x = len - 5;
					s.push_back(8'(8'hC0 | (((off >> 16) & 1) << 4) | ((x >> 8) << 2) | lit));
					s.push_back(8'((off >> 8) & 8'hFF));
					s.push_back(8'(off & 8'hFF));
					s.push_back(8'(x & 8'hFF));
				end
				push_lits(s, lit);
				prod += lit + len;
			end
		end
		lo = (eff + 1 < 8'hE0) ? 8'hE0 : eff + 1;
		if (lo <= 8'hFF) begin
			b = $urandom_range(lo, 255);
			if (eff == 8'hFF) mask = 8'h1F;
			else if (eff == 8'hFE) mask = 0;
			else if (eff == 8'hFD) mask = 1;
			else if (eff >= 8'hFB) mask = 3;
			else if (eff >= 8'hF7) mask = 7;
			else mask = 8'h0F;
			s.push_back(8'(b));
			push_lits(s, b & mask);
			prod += b & mask;
		end
	endfunction

	initial begin
		bit [7:0]    s[$];
		bit [7:0]    thr_set[8];
		int unsigned prod, pick;
		bit [31:0]   size;
		thr_set = '{8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hE0, 8'h10};
		sent = 0;
		calm = 0;
		thr_now = 8'hFB;
		@(posedge arst_n);
		@(posedge clk);

		write_reg(CFG_STOP_THRESHOLD, 8'h00);
		write_reg(CFG_OUTPUT_SIZE, 32'd10);
		send_stream('{8'hE0, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h00,
			8'hFF, 8'h01, 8'h80, 8'h7F});
		send_stream('{8'h80});
		send_stream('{8'hFC, 8'h12});
		drain();
		write_reg(CFG_OUTPUT_SIZE, 32'hFFFF_FFFF);
		send_stream('{8'hE1, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
			8'h77, 8'h88, 8'hFD});
		drain();

		while (sent < 200) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				pick = $urandom_range(0, 8);
				write_reg(CFG_STOP_THRESHOLD,
					pick == 8 ? $urandom_range(0, 255) : thr_set[pick]);
			end
			gen_stream(s, prod);
			size = prod;
			case ($urandom_range(0, 11))
				0: size = prod + 1;
				1: size = prod - 1;
				2: size = 32'hFFFF_FFFF;
				3: if (s.size() > 1) repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
				4: s.push_back(8'($urandom_range(0, 255)));
				5: begin
					s.delete();
					push_lits(s, $urandom_range(1, 8));
					size = $urandom_range(0, 40);
				end
				default: ;
			endcase
			write_reg(CFG_OUTPUT_SIZE, size);
			send_stream(s);
			drain();
		end
		write_reg(CFG_OUTPUT_SIZE, 32'd0);
		send_stream('{8'hFF});
		drain();

		if (model.fails == 0 && model.beats_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
